>>> rtl/fba_pkg.sv
`default_nettype none
package fba_pkg;

  localparam int unsigned FRAME_CAPACITY_DEF = 65536;
  localparam int unsigned PAGE_BYTES_DEF     = 4096;
  localparam int unsigned IDXW               = 17;
  localparam logic [16:0] LIMIT_RESET        = 17'h10000;

  typedef enum logic [2:0] {
    ACT_ALLOC_ONE = 3'd0,
    ACT_ALLOC_RUN = 3'd1,
    ACT_FREE      = 3'd2,
    ACT_MARK      = 3'd3,
    ACT_CLEAR     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_ZERO_RUN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_UPD_RD,
    S_UPD_WR
  } state_e;

  typedef struct packed {
    logic init;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [IDXW-1:0]   start;
  } scan_sts_t;

endpackage
`default_nettype wire

>>> rtl/frame_bitmap_allocator.sv
`default_nettype none
// Frame allocator over a one-bit-per-frame map held in a RAM of 64-bit words.
// An action is taken when start is high and busy is low; its one result is
// shown for a single cycle with done_o and cannot be held off. Allocation
// scans the map eight frames a cycle, less a RAM read per map word, through
// one shared scan unit, then sets the run with a read and a write per word;
// a miss scans up to the frame limit. Free and mark used read the frame's
// word and write it back if the bit changes; unknown actions and zero runs
// do not touch the map. Clear, reset and every frame_limit write clear all
// ceil(FRAME_CAPACITY/64) words (1024 by default) one per cycle, busy high.
module frame_bitmap_allocator #(
  parameter int unsigned FRAME_CAPACITY = fba_pkg::FRAME_CAPACITY_DEF,
  parameter int unsigned PAGE_BYTES     = fba_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action_i,
  input  wire logic [47:0] request_address_i,
  input  wire logic [16:0] run_length_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [27:0]      frame_address_o,
  output logic [16:0]      used_count_o,
  output logic [16:0]      free_count_o
);

  localparam int unsigned MAP_WORDS = (FRAME_CAPACITY + 63) / 64;
  localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PB_SH     = $clog2(PAGE_BYTES);
  localparam int unsigned IW        = fba_pkg::IDXW;

  fba_pkg::state_e state_q, state_d;

  logic [16:0]   limit_q, limit_d;
  logic [IW-1:0] used_q, used_d;
  logic [IW-1:0] i_q, i_d, st_q, st_d, end_q, end_d, m_q, m_d, run_q, run_d;
  logic [IW-1:0] frm_q, frm_d;
  logic          want_q, want_d, report_q, report_d;
  logic [WW-1:0] c_q, c_d;

  logic          done_d;
  logic [1:0]    status_d;
  logic [27:0]   faddr_d;

  logic [IW-1:0] lim;
  logic          cfg_fire, acc;
  logic [47:0]   req_frame;
  logic          req_in_range;
  logic [IW:0]   scan_next;
  logic          scan_over;
  logic [IW:0]   word_next;
  logic          mark_last;
  logic [63:0]   rdata, wmask, chunk_word;
  logic [47:0]   fa_wide;

  logic          ram_we, ram_re;
  logic [WW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata;

  fba_pkg::scan_ctl_t scan_ctl;
  fba_pkg::scan_sts_t scan_sts;

  assign lim = (32'(limit_q) > FRAME_CAPACITY) ? IW'(FRAME_CAPACITY) : limit_q;

  assign cfg_ready_o  = 1'b1;
  assign cfg_fire     = cfg_valid_i && cfg_ready_o;
  assign busy         = (state_q != fba_pkg::S_IDLE);
  assign acc          = start && !busy;
  assign req_frame    = request_address_i >> PB_SH;
  assign req_in_range = (req_frame < {31'b0, lim});
  assign scan_next    = {1'b0, i_q} + (IW+1)'(8);
  assign scan_over    = (scan_next >= {1'b0, lim});
  assign word_next    = {1'b0, m_q | IW'(63)} + (IW+1)'(1);
  assign mark_last    = ((m_q | IW'(63)) >= end_q);
  assign chunk_word   = rdata >> {i_q[5:3], 3'b000};
  assign fa_wide      = {31'b0, st_q} << PB_SH;

  always_comb begin
    for (int b = 0; b < 64; b++) begin
      wmask[b] = ({m_q[IW-1:6], 6'(b)} >= st_q) && ({m_q[IW-1:6], 6'(b)} <= end_q);
    end
  end

  fba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  fba_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .chunk_i (chunk_word[7:0]),
    .base_i  (i_q),
    .lim_i   (lim),
    .run_i   (run_q),
    .sts_o   (scan_sts)
  );

  // next state
  always_comb begin
    state_d = state_q;
    if (cfg_fire) begin
      state_d = fba_pkg::S_CLEAR;
    end else begin
      unique case (state_q)
        fba_pkg::S_CLEAR: begin
          if (c_q == WW'(MAP_WORDS - 1)) state_d = fba_pkg::S_IDLE;
        end
        fba_pkg::S_IDLE: begin
          if (acc) begin
            unique case (action_i)
              fba_pkg::ACT_ALLOC_ONE: begin
                if (lim != '0) state_d = fba_pkg::S_SCAN_RD;
              end
              fba_pkg::ACT_ALLOC_RUN: begin
                if (run_length_i != '0 && lim != '0) state_d = fba_pkg::S_SCAN_RD;
              end
              fba_pkg::ACT_FREE, fba_pkg::ACT_MARK: begin
                if (req_in_range) state_d = fba_pkg::S_UPD_RD;
              end
              fba_pkg::ACT_CLEAR: state_d = fba_pkg::S_CLEAR;
              default: state_d = fba_pkg::S_IDLE;
            endcase
          end
        end
        fba_pkg::S_SCAN_RD: state_d = fba_pkg::S_SCAN;
        fba_pkg::S_SCAN: begin
          if (scan_sts.found) state_d = fba_pkg::S_MARK_RD;
          else if (scan_over) state_d = fba_pkg::S_IDLE;
          else if (i_q[5:3] == 3'd7) state_d = fba_pkg::S_SCAN_RD;
        end
        fba_pkg::S_MARK_RD: state_d = fba_pkg::S_MARK_WR;
        fba_pkg::S_MARK_WR: begin
          state_d = mark_last ? fba_pkg::S_IDLE : fba_pkg::S_MARK_RD;
        end
        fba_pkg::S_UPD_RD: state_d = fba_pkg::S_UPD_WR;
        fba_pkg::S_UPD_WR: state_d = fba_pkg::S_IDLE;
        default: state_d = fba_pkg::S_IDLE;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    limit_d   = limit_q;
    used_d    = used_q;
    i_d       = i_q;
    st_d      = st_q;
    end_d     = end_q;
    m_d       = m_q;
    run_d     = run_q;
    frm_d     = frm_q;
    want_d    = want_q;
    report_d  = report_q;
    c_d       = c_q;
    done_d    = 1'b0;
    status_d  = fba_pkg::ST_IGNORED;
    faddr_d   = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    scan_ctl  = '0;
    if (cfg_fire) begin
      limit_d  = cfg_data_i;
      used_d   = '0;
      c_d      = '0;
      report_d = 1'b0;
    end else begin
      unique case (state_q)
        fba_pkg::S_CLEAR: begin
          ram_we    = 1'b1;
          ram_waddr = c_q;
          c_d       = c_q + 1'b1;
          if (c_q == WW'(MAP_WORDS - 1)) begin
            done_d   = report_q;
            status_d = fba_pkg::ST_DONE;
          end
        end
        fba_pkg::S_IDLE: begin
          if (acc) begin
            i_d           = '0;
            scan_ctl.init = 1'b1;
            frm_d         = req_frame[IW-1:0];
            want_d        = (action_i == fba_pkg::ACT_MARK);
            unique case (action_i)
              fba_pkg::ACT_ALLOC_ONE: begin
                run_d = IW'(1);
                if (lim == '0) begin
                  done_d   = 1'b1;
                  status_d = fba_pkg::ST_NO_SPACE;
                end
              end
              fba_pkg::ACT_ALLOC_RUN: begin
                run_d = run_length_i;
                if (run_length_i == '0) begin
                  done_d   = 1'b1;
                  status_d = fba_pkg::ST_ZERO_RUN;
                end else if (lim == '0) begin
                  done_d   = 1'b1;
                  status_d = fba_pkg::ST_NO_SPACE;
                end
              end
              fba_pkg::ACT_FREE, fba_pkg::ACT_MARK: begin
                if (!req_in_range) begin
                  done_d   = 1'b1;
                  status_d = fba_pkg::ST_IGNORED;
                end
              end
              fba_pkg::ACT_CLEAR: begin
                used_d   = '0;
                c_d      = '0;
                report_d = 1'b1;
              end
              default: begin
                done_d   = 1'b1;
                status_d = fba_pkg::ST_IGNORED;
              end
            endcase
          end
        end
        fba_pkg::S_SCAN_RD: begin
          ram_re    = 1'b1;
          ram_raddr = WW'(i_q >> 6);
        end
        fba_pkg::S_SCAN: begin
          scan_ctl.step = 1'b1;
          i_d           = scan_next[IW-1:0];
          if (scan_sts.found) begin
            st_d  = scan_sts.start;
            m_d   = scan_sts.start;
            end_d = scan_sts.start + run_q - 1'b1;
          end else if (scan_over) begin
            done_d   = 1'b1;
            status_d = fba_pkg::ST_NO_SPACE;
          end
        end
        fba_pkg::S_MARK_RD: begin
          ram_re    = 1'b1;
          ram_raddr = WW'(m_q >> 6);
        end
        fba_pkg::S_MARK_WR: begin
          ram_we    = 1'b1;
          ram_waddr = WW'(m_q >> 6);
          ram_wdata = rdata | wmask;
          m_d       = word_next[IW-1:0];
          if (mark_last) begin
            used_d   = used_q + run_q;
            done_d   = 1'b1;
            status_d = fba_pkg::ST_DONE;
            faddr_d  = fa_wide[27:0];
          end
        end
        fba_pkg::S_UPD_RD: begin
          ram_re    = 1'b1;
          ram_raddr = WW'(frm_q >> 6);
        end
        fba_pkg::S_UPD_WR: begin
          done_d = 1'b1;
          if (rdata[frm_q[5:0]] != want_q) begin
            ram_we    = 1'b1;
            ram_waddr = WW'(frm_q >> 6);
            ram_wdata = rdata ^ (64'd1 << frm_q[5:0]);
            status_d  = fba_pkg::ST_DONE;
            if (want_q) used_d = used_q + 1'b1;
            else if (used_q != '0) used_d = used_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fba_pkg::S_CLEAR;
      limit_q  <= fba_pkg::LIMIT_RESET;
      used_q   <= '0;
      c_q      <= '0;
      report_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      limit_q  <= limit_d;
      used_q   <= used_d;
      c_q      <= c_d;
      report_q <= report_d;
      done_o   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q             <= i_d;
    st_q            <= st_d;
    end_q           <= end_d;
    m_q             <= m_d;
    run_q           <= run_d;
    frm_q           <= frm_d;
    want_q          <= want_d;
    status_o        <= status_d;
    frame_address_o <= faddr_d;
    used_count_o    <= used_d;
    free_count_o    <= (lim > used_d) ? (lim - used_d) : '0;
  end

endmodule
`default_nettype wire

>>> rtl/fba_map_ram.sv
`default_nettype none
module fba_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [63:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [63:0]   rdata_o
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/fba_scan.sv
`default_nettype none
module fba_scan (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire fba_pkg::scan_ctl_t       ctl_i,
  input  wire logic [7:0]               chunk_i,
  input  wire logic [fba_pkg::IDXW-1:0] base_i,
  input  wire logic [fba_pkg::IDXW-1:0] lim_i,
  input  wire logic [fba_pkg::IDXW-1:0] run_i,
  output fba_pkg::scan_sts_t            sts_o
);

  logic [fba_pkg::IDXW-1:0] cnt_q, cnt_d, start_q, start_d;

  always_comb begin
    logic                   fnd;
    logic [fba_pkg::IDXW:0] idx;
    cnt_d   = cnt_q;
    start_d = start_q;
    fnd     = 1'b0;
    idx     = '0;
    // run of free frames carries across chunks and words
    for (int b = 0; b < 8; b++) begin
      idx = {1'b0, base_i} + (fba_pkg::IDXW+1)'(b);
      if (!fnd) begin
        if (!chunk_i[b] && (idx < {1'b0, lim_i})) begin
          if (cnt_d == '0) begin
            start_d = idx[fba_pkg::IDXW-1:0];
          end
          cnt_d = cnt_d + 1'b1;
          if (cnt_d == run_i) begin
            fnd = 1'b1;
          end
        end else begin
          cnt_d = '0;
        end
      end
    end
    sts_o.found = fnd;
    sts_o.start = start_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      start_q <= '0;
    end else if (ctl_i.init) begin
      cnt_q   <= '0;
      start_q <= '0;
    end else if (ctl_i.step) begin
      cnt_q   <= cnt_d;
      start_q <= start_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fba_checker.sv
`default_nettype none
module fba_checker #(
  parameter int unsigned PAGE_BYTES = fba_pkg::PAGE_BYTES_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  action_i,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [27:0] frame_address_o
);

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != fba_pkg::ST_DONE) |-> frame_address_o == '0)
    else $error("frame address set on a failed result");

  a_addr_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (frame_address_o & 28'(PAGE_BYTES - 1)) == '0)
    else $error("frame address not page aligned");

  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> busy)
    else $error("limit write did not start the clearing pass");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (action_i == fba_pkg::ACT_CLEAR) && !cfg_valid_i |=> busy && !done_o)
    else $error("clear action did not run the clearing pass");

endmodule

bind frame_bitmap_allocator fba_checker #(.PAGE_BYTES(PAGE_BYTES)) u_fba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .start           (start),
  .busy            (busy),
  .action_i        (action_i),
  .done_o          (done_o),
  .status_o        (status_o),
  .frame_address_o (frame_address_o)
);
`default_nettype wire

>>> bench/frame_alloc_checker.sv
module frame_alloc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [16:0] cfg_data_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  action_i,
  input  logic [47:0] request_address_i,
  input  logic [16:0] run_length_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [27:0] frame_address_i,
  input  logic [16:0] used_count_i,
  input  logic [16:0] free_count_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES = fba_pkg::FRAME_CAPACITY_DEF;
  localparam int unsigned PAGE   = fba_pkg::PAGE_BYTES_DEF;

  typedef struct {
    fba_pkg::status_e status;
    logic [27:0]      frame_address;
    logic [16:0]      used_count;
    logic [16:0]      free_count;
  } alloc_word_t;

  bit          frame_used[FRAMES];
  int unsigned frames_taken;
  int unsigned limit_reg;
  alloc_word_t expected_words[$];

  function automatic int unsigned live_limit();
    return (limit_reg > FRAMES) ? FRAMES : limit_reg;
  endfunction

  function automatic void wipe_map();
    foreach (frame_used[i]) frame_used[i] = 1'b0;
    frames_taken = 0;
  endfunction

  function automatic alloc_word_t allocate_frames(logic [2:0] act, logic [47:0] addr,
                                                  logic [16:0] run);
    alloc_word_t w;
    int unsigned lim, count, first, fnum;
    logic [47:0] frame;
    bit want;
    lim = live_limit();
    w.status = fba_pkg::ST_IGNORED;
    w.frame_address = '0;
    count = 0;
    first = 0;
    case (act)
      fba_pkg::ACT_ALLOC_ONE: begin
        w.status = fba_pkg::ST_NO_SPACE;
        for (int unsigned i = 0; i < lim; i++) begin
          if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            frames_taken++;
            w.status = fba_pkg::ST_DONE;
            w.frame_address = 28'(i * PAGE);
            break;
          end
        end
      end
      fba_pkg::ACT_ALLOC_RUN: begin
        if (run == 0) begin
          w.status = fba_pkg::ST_ZERO_RUN;
        end else begin
          w.status = fba_pkg::ST_NO_SPACE;
          for (int unsigned i = 0; i < lim; i++) begin
            if (!frame_used[i]) begin
              if (count == 0) first = i;
              count++;
              if (count == run) begin
                for (int unsigned j = first; j <= i; j++) frame_used[j] = 1'b1;
                frames_taken += 32'(run);
                w.status = fba_pkg::ST_DONE;
                w.frame_address = 28'(first * PAGE);
                break;
              end
            end else begin
              count = 0;
            end
          end
        end
      end
      fba_pkg::ACT_FREE, fba_pkg::ACT_MARK: begin
        frame = addr / 48'(PAGE);
        want = (act == fba_pkg::ACT_MARK);
        if (frame < 48'(lim)) begin
          fnum = frame[31:0];
          if (frame_used[fnum] != want) begin
            frame_used[fnum] = want;
            if (want) frames_taken++;
            else if (frames_taken > 0) frames_taken--;
            w.status = fba_pkg::ST_DONE;
          end
        end
      end
      fba_pkg::ACT_CLEAR: begin
        wipe_map();
        w.status = fba_pkg::ST_DONE;
      end
      default: ;
    endcase
    if (w.status != fba_pkg::ST_DONE) w.frame_address = '0;
    w.used_count = 17'(frames_taken);
    w.free_count = 17'((lim > frames_taken) ? lim - frames_taken : 0);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_word_t exp_w;
    if (!rst_ni) begin
      wipe_map();
      limit_reg = 32'(fba_pkg::LIMIT_RESET);
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (done_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word, status %0d", status_i);
          fail_count_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (status_i !== exp_w.status) begin
            $error("status: expected %0d, actual %0d", exp_w.status, status_i);
            fail_count_o++;
          end
          if (frame_address_i !== exp_w.frame_address) begin
            $error("frame_address: expected %h, actual %h", exp_w.frame_address,
                   frame_address_i);
            fail_count_o++;
          end
          if (used_count_i !== exp_w.used_count) begin
            $error("used_count: expected %0d, actual %0d", exp_w.used_count, used_count_i);
            fail_count_o++;
          end
          if (free_count_i !== exp_w.free_count) begin
            $error("free_count: expected %0d, actual %0d", exp_w.free_count, free_count_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        limit_reg = 32'(cfg_data_i);
        wipe_map();
      end
      if (start_i && !busy_i)
        expected_words.push_back(allocate_frames(action_i, request_address_i, run_length_i));
    end
    pending_o = expected_words.size();
  end
endmodule

>>> bench/frame_bitmap_allocator_tb.sv
module frame_bitmap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int unsigned PAGE  = fba_pkg::PAGE_BYTES_DEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action = fba_pkg::ACT_CLEAR;
  logic [47:0] req_addr = '0;
  logic [16:0] run_len = '0;
  logic        done;
  logic [1:0]  status;
  logic [27:0] frame_addr;
  logic [16:0] used_cnt, free_cnt;
  int          fail_count, pending;
  int          idle_cycles = 0;
  int unsigned cur_limit = 32'(fba_pkg::LIMIT_RESET);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frame_bitmap_allocator u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .start(start), .busy(busy),
    .action_i(action), .request_address_i(req_addr), .run_length_i(run_len),
    .done_o(done), .status_o(status), .frame_address_o(frame_addr),
    .used_count_o(used_cnt), .free_count_o(free_cnt)
  );

  frame_alloc_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .start_i(start), .busy_i(busy),
    .action_i(action), .request_address_i(req_addr), .run_length_i(run_len),
    .done_i(done), .status_i(status), .frame_address_i(frame_addr),
    .used_count_i(used_cnt), .free_count_i(free_cnt),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: any accepted word counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("frame_bitmap_allocator_tb: FAIL");
      $finish;
    end
  end

  task automatic issue(fba_pkg::action_e act, logic [47:0] addr, logic [16:0] run);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    action   <= act;
    req_addr <= addr;
    run_len  <= run;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue_raw(logic [2:0] act, logic [47:0] addr, logic [16:0] run);
    issue(fba_pkg::action_e'(act), addr, run);
  endtask

  task automatic write_limit(logic [16:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = (32'(value) > fba_pkg::FRAME_CAPACITY_DEF) ? fba_pkg::FRAME_CAPACITY_DEF
                                                            : 32'(value);
  endtask

  function automatic logic [47:0] pick_address(int unsigned lim);
    logic [47:0] a;
    if ($urandom_range(0, 9) == 0) begin
      a = 48'({$urandom, $urandom});
    end else begin
      a = 48'($urandom_range(0, lim + 2)) * 48'(PAGE);
      a[11:0] = 12'($urandom);
    end
    return a;
  endfunction

  task automatic random_items(int count, bit wide_runs);
    int sel;
    logic [16:0] run;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (wide_runs && $urandom_range(0, 9) == 0) run = 17'($urandom);
      else if ($urandom_range(0, 19) == 0) run = '0;
      else run = 17'($urandom_range(1, 40));
      if (sel < 30)      issue(fba_pkg::ACT_ALLOC_ONE, '0, run);
      else if (sel < 55) issue(fba_pkg::ACT_ALLOC_RUN, 48'({$urandom, $urandom}), run);
      else if (sel < 75) issue(fba_pkg::ACT_FREE, pick_address(cur_limit), run);
      else if (sel < 92) issue(fba_pkg::ACT_MARK, pick_address(cur_limit), run);
      else if (sel < 95) issue(fba_pkg::ACT_CLEAR, 48'({$urandom, $urandom}),
                               17'($urandom));
      else issue_raw(3'($urandom_range(5, 7)), 48'({$urandom, $urandom}), 17'($urandom));
    end
  endtask

  initial begin
    logic [16:0] limits[8];
    limits = '{17'd0, 17'd1, 17'd64, 17'd65, 17'd200, 17'h1FFFF, 17'd130, 17'h10000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(fba_pkg::ACT_ALLOC_ONE, '0, '0);
    issue(fba_pkg::ACT_ALLOC_RUN, '0, 17'd1);
    issue(fba_pkg::ACT_ALLOC_RUN, '0, 17'd0);
    issue(fba_pkg::ACT_ALLOC_RUN, '0, 17'h10000);
    issue(fba_pkg::ACT_FREE, '0, '0);
    issue(fba_pkg::ACT_MARK, 48'd4095, '0);
    issue(fba_pkg::ACT_MARK, 48'd4096, '0);
    issue(fba_pkg::ACT_FREE, 48'd40960, '0);
    issue(fba_pkg::ACT_MARK, 48'hFFFF_FFFF_FFFF, '0);
    issue(fba_pkg::ACT_MARK, 48'd65535 * 48'(PAGE) + 48'd4095, '0);
    issue(fba_pkg::ACT_FREE, 48'd65536 * 48'(PAGE), '0);
    issue(fba_pkg::ACT_ALLOC_ONE, '0, '0);
    issue_raw(3'd5, '0, '0);
    issue_raw(3'd6, 48'hFFFF_FFFF_FFFF, 17'h1FFFF);
    issue_raw(3'd7, '0, '0);
    issue(fba_pkg::ACT_CLEAR, '0, '0);
    issue(fba_pkg::ACT_ALLOC_RUN, '0, 17'h10000);
    issue(fba_pkg::ACT_ALLOC_ONE, '0, '0);
    issue(fba_pkg::ACT_FREE, 48'd123 * 48'(PAGE), '0);
    issue(fba_pkg::ACT_ALLOC_RUN, '0, 17'd2);
    issue(fba_pkg::ACT_ALLOC_ONE, '0, '0);
    issue(fba_pkg::ACT_CLEAR, '0, '0);
    random_items(150, 1'b0);

    // small limits keep full-map scans cheap
    foreach (limits[k]) begin
      write_limit(limits[k]);
      random_items(155, cur_limit < 1024);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("frame_bitmap_allocator_tb: PASS");
    else $display("frame_bitmap_allocator_tb: FAIL");
    $finish;
  end
endmodule

>>> files.f
rtl/fba_pkg.sv
rtl/fba_map_ram.sv
rtl/fba_scan.sv
rtl/frame_bitmap_allocator.sv
rtl/fba_checker.sv
bench/frame_alloc_checker.sv
bench/frame_bitmap_allocator_tb.sv
